>>> sv/hrf_pkg.sv
// Shared types and constants for the heightmap region flatten unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package hrf_pkg;

  localparam int unsigned SIDE_W  = 9;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned GRAD_W  = 17;
  localparam int unsigned REQ_W   = 2;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 9'd256;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_FLATTEN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CUTOUT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  // Height store read address: this tile, the tile to the right, the tile below.
  typedef enum logic [1:0] {
    ASEL_TILE,
    ASEL_RIGHT,
    ASEL_DOWN
  } hrf_asel_e;

  typedef struct packed {
    logic      capture;   // latch the request fields
    logic      bounds;    // compute the clipped rectangle bounds
    logic      start_h;   // start a sweep of the request rectangle
    logic      start_g;   // start a sweep of the widened gradient rectangle
    logic      step;      // advance to the next tile of the sweep
    logic      clr_step;  // advance the clearing counter
    logic      clear_we;  // write reset values at the clearing counter
    logic      h_we;      // write the level into the height store
    logic      p_we;      // clear the present flag
    logic      g_we;      // write the gradients of the current tile
    logic      h_re;      // read the height store
    logic      rd_all;    // read all four stores
    logic      cap_hk;    // capture the height of this tile
    logic      cap_hr;    // capture the height of the right neighbor
    hrf_asel_e asel;
    logic      load_out;  // load the result register
  } hrf_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             h_empty;
    logic             g_empty;
    logic             tile_last;
    logic             clr_last;
  } hrf_sts_t;

endpackage

>>> sv/hrf_ram.sv
// Generic simple dual port RAM: one write port, one read port with registered read.
// Stand-alone; no package dependencies.
module hrf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/hrf_ctrl.sv
// Controller state machine of the heightmap region flatten unit.
// Depends on hrf_pkg for the command and status structs and the request codes.
module hrf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  hrf_pkg::hrf_sts_t sts_i,
  output hrf_pkg::hrf_cmd_t cmd_o
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_SETUP  = 4'd2;
  localparam logic [3:0] ST_PREP_H = 4'd3;
  localparam logic [3:0] ST_HGT    = 4'd4;
  localparam logic [3:0] ST_PREP_G = 4'd5;
  localparam logic [3:0] ST_G0     = 4'd6;
  localparam logic [3:0] ST_G1     = 4'd7;
  localparam logic [3:0] ST_G2     = 4'd8;
  localparam logic [3:0] ST_G3     = 4'd9;
  localparam logic [3:0] ST_CUT    = 4'd10;
  localparam logic [3:0] ST_RD     = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.asel  = hrf_pkg::ASEL_TILE;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.bounds = 1'b1;
        if (sts_i.req_type == hrf_pkg::REQ_FLATTEN || sts_i.req_type == hrf_pkg::REQ_CUTOUT ||
            sts_i.req_type == hrf_pkg::REQ_READ) begin
          state_d = ST_PREP_H;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PREP_H: begin
        cmd_o.start_h = 1'b1;
        case (sts_i.req_type)
          hrf_pkg::REQ_FLATTEN: state_d = sts_i.h_empty ? ST_PREP_G : ST_HGT;
          hrf_pkg::REQ_CUTOUT:  state_d = sts_i.h_empty ? ST_DONE : ST_CUT;
          hrf_pkg::REQ_READ:    state_d = ST_RD;
          default:              state_d = ST_DONE;
        endcase
      end
      ST_HGT: begin
        cmd_o.h_we = 1'b1;
        cmd_o.step = 1'b1;
        if (sts_i.tile_last) begin
          state_d = ST_PREP_G;
        end
      end
      ST_PREP_G: begin
        cmd_o.start_g = 1'b1;
        state_d = sts_i.g_empty ? ST_DONE : ST_G0;
      end
      ST_G0: begin
        cmd_o.h_re = 1'b1;
        cmd_o.asel = hrf_pkg::ASEL_TILE;
        state_d    = ST_G1;
      end
      ST_G1: begin
        cmd_o.h_re   = 1'b1;
        cmd_o.asel   = hrf_pkg::ASEL_RIGHT;
        cmd_o.cap_hk = 1'b1;
        state_d      = ST_G2;
      end
      ST_G2: begin
        cmd_o.h_re   = 1'b1;
        cmd_o.asel   = hrf_pkg::ASEL_DOWN;
        cmd_o.cap_hr = 1'b1;
        state_d      = ST_G3;
      end
      ST_G3: begin
        cmd_o.g_we = 1'b1;
        cmd_o.step = 1'b1;
        state_d    = sts_i.tile_last ? ST_DONE : ST_G0;
      end
      ST_CUT: begin
        cmd_o.p_we = 1'b1;
        cmd_o.step = 1'b1;
        if (sts_i.tile_last) begin
          state_d = ST_DONE;
        end
      end
      ST_RD: begin
        cmd_o.rd_all = 1'b1;
        cmd_o.asel   = hrf_pkg::ASEL_TILE;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/hrf_dpath.sv
// Datapath of the heightmap region flatten unit: request and bound registers,
// tile sweep counters, the four tile stores and the result register.
// Depends on hrf_pkg and hrf_ram.
module hrf_dpath #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hrf_pkg::SIDE_W-1:0]          cfg_data_i,
  input  logic [hrf_pkg::REQ_W-1:0]           req_type_i,
  input  logic [hrf_pkg::COORD_W-1:0]         row_start_i,
  input  logic [hrf_pkg::COORD_W-1:0]         col_start_i,
  input  logic [hrf_pkg::SIDE_W-1:0]          row_span_i,
  input  logic [hrf_pkg::SIDE_W-1:0]          col_span_i,
  input  logic signed [hrf_pkg::LEVEL_W-1:0]  level_i,
  input  hrf_pkg::hrf_cmd_t                   cmd_i,
  output hrf_pkg::hrf_sts_t                   sts_o,
  output logic signed [hrf_pkg::LEVEL_W-1:0]  tile_height_o,
  output logic signed [hrf_pkg::GRAD_W-1:0]   tile_grad_x_o,
  output logic signed [hrf_pkg::GRAD_W-1:0]   tile_grad_z_o,
  output logic                                tile_present_o
);

  localparam int unsigned Depth   = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned SideMax = (1 << hrf_pkg::SIDE_W) - 1;
  localparam int unsigned SideCap = (MAX_SIDE > SideMax) ? SideMax : MAX_SIDE;
  localparam int unsigned SW      = hrf_pkg::SIDE_W;
  localparam int unsigned CW      = hrf_pkg::COORD_W;

  // Configuration and clearing counter.
  logic [SW-1:0]    grid_side_q;
  logic [SW-1:0]    side;
  logic [AddrW-1:0] clr_q;

  // Request and bounds.
  logic [hrf_pkg::REQ_W-1:0]   req_q;
  logic [CW-1:0]               r0_q, c0_q, rb_q, cb_q;
  logic [SW-1:0]               rs_q, cs_q;
  logic [hrf_pkg::LEVEL_W-1:0] lvl_q;
  logic [SW-1:0]               r_end_q, c_end_q;
  logic [SW:0]                 r_sum, c_sum;

  // Sweep.
  logic [SW-1:0]     i_q, j_q, col_first_q;
  logic [AddrW-1:0]  row_base_q;
  logic [CW-1:0]     mul_row;
  logic [CW+SW-1:0]  mul_prod;
  logic [AddrW-1:0]  tile_addr, rd_addr, wr_addr;
  logic              col_last, row_last, has_right, has_down;

  // Stores.
  logic [hrf_pkg::LEVEL_W-1:0] h_rdata, h_wdata, h_k_q, h_r_q;
  logic [hrf_pkg::GRAD_W-1:0]  gx_rdata, gz_rdata, gx_val, gz_val, gx_wdata, gz_wdata;
  logic                        p_rdata;
  logic                        h_we, p_we, gx_we, gz_we;
  logic                        read_hit;

  always_comb begin
    if (grid_side_q > SW'(SideCap)) begin
      side = SW'(SideCap);
    end else begin
      side = grid_side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= hrf_pkg::GRID_SIDE_RST;
      clr_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        grid_side_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AddrW'(1);
      end
    end
  end

  assign r_sum = (SW+1)'(r0_q) + (SW+1)'(rs_q);
  assign c_sum = (SW+1)'(c0_q) + (SW+1)'(cs_q);

  assign mul_row  = cmd_i.start_g ? rb_q : r0_q;
  assign mul_prod = (CW+SW)'(mul_row) * (CW+SW)'(side);

  assign col_last = ((SW+1)'(j_q) + (SW+1)'(1)) == (SW+1)'(c_end_q);
  assign row_last = ((SW+1)'(i_q) + (SW+1)'(1)) == (SW+1)'(r_end_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      r0_q  <= row_start_i;
      c0_q  <= col_start_i;
      rs_q  <= row_span_i;
      cs_q  <= col_span_i;
      lvl_q <= level_i;
    end
    if (cmd_i.bounds) begin
      r_end_q <= (r_sum < (SW+1)'(side)) ? r_sum[SW-1:0] : side;
      c_end_q <= (c_sum < (SW+1)'(side)) ? c_sum[SW-1:0] : side;
      rb_q    <= (r0_q == '0) ? '0 : r0_q - CW'(1);
      cb_q    <= (c0_q == '0) ? '0 : c0_q - CW'(1);
    end
    if (cmd_i.start_h || cmd_i.start_g) begin
      i_q         <= SW'(mul_row);
      j_q         <= cmd_i.start_g ? SW'(cb_q) : SW'(c0_q);
      col_first_q <= cmd_i.start_g ? SW'(cb_q) : SW'(c0_q);
      row_base_q  <= AddrW'(mul_prod);
    end else if (cmd_i.step) begin
      if (col_last) begin
        j_q        <= col_first_q;
        i_q        <= i_q + SW'(1);
        row_base_q <= row_base_q + AddrW'(side);
      end else begin
        j_q <= j_q + SW'(1);
      end
    end
    if (cmd_i.cap_hk) begin
      h_k_q <= h_rdata;
    end
    if (cmd_i.cap_hr) begin
      h_r_q <= h_rdata;
    end
  end

  assign tile_addr = row_base_q + AddrW'(j_q);

  always_comb begin
    case (cmd_i.asel)
      hrf_pkg::ASEL_TILE:  rd_addr = tile_addr;
      hrf_pkg::ASEL_RIGHT: rd_addr = tile_addr + AddrW'(1);
      hrf_pkg::ASEL_DOWN:  rd_addr = tile_addr + AddrW'(side);
      default:             rd_addr = tile_addr;
    endcase
  end

  assign wr_addr = cmd_i.clear_we ? clr_q : tile_addr;

  // The last column has no x-gradient and the last row no z-gradient.
  assign has_right = ((SW+1)'(j_q) + (SW+1)'(1)) < (SW+1)'(side);
  assign has_down  = ((SW+1)'(i_q) + (SW+1)'(1)) < (SW+1)'(side);

  assign gx_val = {h_r_q[hrf_pkg::LEVEL_W-1], h_r_q} - {h_k_q[hrf_pkg::LEVEL_W-1], h_k_q};
  assign gz_val = {h_rdata[hrf_pkg::LEVEL_W-1], h_rdata} - {h_k_q[hrf_pkg::LEVEL_W-1], h_k_q};

  assign h_we     = cmd_i.clear_we || cmd_i.h_we;
  assign p_we     = cmd_i.clear_we || cmd_i.p_we;
  assign gx_we    = cmd_i.clear_we || (cmd_i.g_we && has_right);
  assign gz_we    = cmd_i.clear_we || (cmd_i.g_we && has_down);
  assign h_wdata  = cmd_i.clear_we ? '0 : lvl_q;
  assign gx_wdata = cmd_i.clear_we ? '0 : gx_val;
  assign gz_wdata = cmd_i.clear_we ? '0 : gz_val;

  hrf_ram #(.WIDTH(hrf_pkg::LEVEL_W), .DEPTH(Depth)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (wr_addr),
    .wdata_i (h_wdata),
    .re_i    (cmd_i.h_re || cmd_i.rd_all),
    .raddr_i (rd_addr),
    .rdata_o (h_rdata)
  );

  hrf_ram #(.WIDTH(hrf_pkg::GRAD_W), .DEPTH(Depth)) u_grad_x_ram (
    .clk_i   (clk_i),
    .we_i    (gx_we),
    .waddr_i (wr_addr),
    .wdata_i (gx_wdata),
    .re_i    (cmd_i.rd_all),
    .raddr_i (rd_addr),
    .rdata_o (gx_rdata)
  );

  hrf_ram #(.WIDTH(hrf_pkg::GRAD_W), .DEPTH(Depth)) u_grad_z_ram (
    .clk_i   (clk_i),
    .we_i    (gz_we),
    .waddr_i (wr_addr),
    .wdata_i (gz_wdata),
    .re_i    (cmd_i.rd_all),
    .raddr_i (rd_addr),
    .rdata_o (gz_rdata)
  );

  // Present flags reset to one; a cutout writes zero.
  hrf_ram #(.WIDTH(1), .DEPTH(Depth)) u_present_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (wr_addr),
    .wdata_i (cmd_i.clear_we),
    .re_i    (cmd_i.rd_all),
    .raddr_i (rd_addr),
    .rdata_o (p_rdata)
  );

  assign read_hit = (req_q == hrf_pkg::REQ_READ) && (SW'(r0_q) < side) && (SW'(c0_q) < side);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      tile_height_o  <= read_hit ? h_rdata : '0;
      tile_grad_x_o  <= read_hit ? gx_rdata : '0;
      tile_grad_z_o  <= read_hit ? gz_rdata : '0;
      tile_present_o <= read_hit ? p_rdata : 1'b0;
    end
  end

  assign sts_o.req_type  = req_q;
  assign sts_o.h_empty   = !((SW'(r0_q) < r_end_q) && (SW'(c0_q) < c_end_q));
  assign sts_o.g_empty   = !((SW'(rb_q) < r_end_q) && (SW'(cb_q) < c_end_q));
  assign sts_o.tile_last = col_last && row_last;
  assign sts_o.clr_last  = (clr_q == AddrW'(Depth - 1));

endmodule

>>> sv/heightmap_region_flatten_unit.sv
// Heightmap region flatten unit: top level joining controller and datapath.
// One request is worked on at a time; the single read port of the height store makes
// the controller read a gradient tile, its right and its lower neighbor in turn.
// After reset a clearing pass writes reset values to all MAX_SIDE * MAX_SIDE entries
// of the stores while in_stall_o stays high.
module heightmap_region_flatten_unit #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: grid side register.
  input  logic                                cfg_we_i,
  input  logic [hrf_pkg::SIDE_W-1:0]          cfg_data_i,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hrf_pkg::REQ_W-1:0]           req_type_i,
  input  logic [hrf_pkg::COORD_W-1:0]         row_start_i,
  input  logic [hrf_pkg::COORD_W-1:0]         col_start_i,
  input  logic [hrf_pkg::SIDE_W-1:0]          row_span_i,
  input  logic [hrf_pkg::SIDE_W-1:0]          col_span_i,
  input  logic signed [hrf_pkg::LEVEL_W-1:0]  level_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hrf_pkg::LEVEL_W-1:0]  tile_height_o,
  output logic signed [hrf_pkg::GRAD_W-1:0]   tile_grad_x_o,
  output logic signed [hrf_pkg::GRAD_W-1:0]   tile_grad_z_o,
  output logic                                tile_present_o
);

  // The controller sequences each request: a flatten first sweeps the clipped
  // rectangle writing the level, then sweeps the rectangle widened by one row and
  // one column before it, reading each tile, its right and its lower neighbor and
  // writing the gradients it has. A cutout sweeps the rectangle clearing present flags.
  // A read fetches one tile from all four stores. Every request ends with one
  // result in the output register; the next request is accepted while that result
  // still waits to be taken.
  hrf_pkg::hrf_cmd_t cmd;
  hrf_pkg::hrf_sts_t sts;

  hrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hrf_dpath #(.MAX_SIDE(MAX_SIDE)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .row_start_i    (row_start_i),
    .col_start_i    (col_start_i),
    .row_span_i     (row_span_i),
    .col_span_i     (col_span_i),
    .level_i        (level_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .tile_height_o  (tile_height_o),
    .tile_grad_x_o  (tile_grad_x_o),
    .tile_grad_z_o  (tile_grad_z_o),
    .tile_present_o (tile_present_o)
  );

  // Only one source may write the stores in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear_we, cmd.h_we, cmd.p_we, cmd.g_we}))
    else $error("more than one store write source active");

  // A request is never accepted while a sweep is still writing the stores.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(cmd.clear_we || cmd.h_we || cmd.p_we || cmd.g_we))
    else $error("request accepted during a store sweep");

  // The result register is only loaded when the pending result has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule
